// File: hw/rtl/tqm_pkg.sv
// shared types and constants for the timer queue manager
`timescale 1ns / 1ps
package tqm_pkg;
   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W = $clog2(TIMER_SLOTS);
   localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
   localparam logic [31:0] DEFAULT_WINDOW = 32'd3600000;
   localparam logic [63:0] ALL_ONES = '1;

   typedef enum logic [2:0] {
      KIND_ADD = 3'd0, KIND_CANCEL = 3'd1, KIND_REFRESH = 3'd2, KIND_RESET = 3'd3,
      KIND_WAIT = 3'd4, KIND_EXPIRE = 3'd5, KIND_ANY = 3'd6, KIND_NONE = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_INACTIVE = 2'd1, ST_FULL = 2'd2, ST_NONE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE, FSM_SCAN, FSM_APPLY, FSM_XSCAN, FSM_XEMIT, FSM_DONE
   } fsm_type;

   // one step request to the shared compare unit
   typedef struct packed {
      logic        first;
      logic        cand;
      logic [63:0] key;
      logic [SLOT_W-1:0] idx;
   } cmp_req_type;
endpackage

// File: hw/rtl/tqm_min_unit.sv
// shared running-minimum unit: one candidate per cycle, ordered by key then slot
`timescale 1ns / 1ps
module tqm_min_unit import tqm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmp_req_type       req,
   output logic              found,
   output logic [63:0]       best_key,
   output logic [SLOT_W-1:0] best_idx
);
   logic found_ff, found_in;
   logic [63:0] key_ff, key_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic better;

   // candidate wins on smaller key, or equal key and lower slot
   always_comb begin
      better = req.cand && (!found_ff || req.first || req.key < key_ff ||
               (req.key == key_ff && req.idx < idx_ff));
      found_in = req.first ? req.cand : (found_ff | req.cand);
      key_in = better ? req.key : key_ff;
      idx_in = better ? req.idx : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      key_ff <= key_in;
      idx_ff <= idx_in;
   end

   assign found = found_ff;
   assign best_key = key_ff;
   assign best_idx = idx_ff;
endmodule

// File: hw/rtl/timer_queue_manager.sv
// top level of the timer queue manager: slot table and sequencer
`timescale 1ns / 1ps
// Timer queue manager. Pulse start with an operation while busy is low; the
// block answers with one or more results, each shown for one cycle under
// rsp_valid, the final one with rsp_last set. Results cannot be held off.
// Every operation walks the sixteen slots through one shared minimum unit,
// one slot per cycle, then applies the change; a single-result operation
// then issues its result before the next start is possible. An expire that
// lists timers adds, per listed timer, one walk over the sixteen slots and
// an emit step. The window register may be written through the csr_
// channel while the block is idle and start is low.
module timer_queue_manager import tqm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [3:0]  req_slot,
   input  logic [63:0] req_interval_ms,
   input  logic        req_recurring,
   input  logic        req_from_now,
   input  logic [63:0] req_now_ms,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_result_slot,
   output logic [63:0] rsp_wait_ms,
   output logic        rsp_front_notify,
   output logic        rsp_any_active,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   // slot table
   logic [63:0] deadline_ff [TIMER_SLOTS];
   logic [63:0] period_ff [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] repeats_ff, active_ff, due_ff;
   logic [63:0] snap_ff [TIMER_SLOTS];
   logic notice_ff;
   logic [63:0] prev_ff;
   logic [31:0] window_ff;

   // latched item
   kind_type kind_ff;
   logic [3:0] slot_ff;
   logic [63:0] ival_ff, now_ff;
   logic rec_ff, fnow_ff;

   fsm_type state_ff, state_in;
   logic [SLOT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] nres_ff;
   logic free_found_ff;
   logic [SLOT_W-1:0] free_ff;

   cmp_req_type creq;
   logic found;
   logic [63:0] best_key;
   logic [SLOT_W-1:0] best_idx;

   logic sel_ok;
   logic [SLOT_W-1:0] sidx, tgt;
   logic scan_end, noop_reset, roll, roll_ff, xlast;
   logic [63:0] new_dl, new_dl_ff;
   logic add_ok, reset_ok, front_hit, expire_go, ap_notify;
   status_type ap_status;
   logic [63:0] ap_wait;

   tqm_min_unit u_min (
      .clock(clock), .reset(reset), .req(creq),
      .found(found), .best_key(best_key), .best_idx(best_idx)
   );

   assign sel_ok = {1'b0, slot_ff} < 5'(TIMER_SLOTS);
   assign sidx = slot_ff[SLOT_W-1:0];
   assign tgt = (kind_ff == KIND_ADD) ? free_ff : sidx;

   // shared unit feed: plain scan over deadlines or expiry scan over snapshot;
   // a reset leaves its own slot out so the front check sees the others only
   always_comb begin
      creq.first = (cnt_ff == '0);
      creq.idx = cnt_ff;
      if (state_ff == FSM_XSCAN) begin
         creq.cand = due_ff[cnt_ff];
         creq.key = snap_ff[cnt_ff];
      end else begin
         creq.cand = (state_ff == FSM_SCAN) && active_ff[cnt_ff] &&
                     !(kind_ff == KIND_RESET && cnt_ff == sidx);
         creq.key = deadline_ff[cnt_ff];
      end
   end

   assign scan_end = (cnt_ff == SLOT_W'(TIMER_SLOTS - 1));
   assign noop_reset = sel_ok && ival_ff == period_ff[sidx] && !fnow_ff;
   assign roll = now_ff < prev_ff && (prev_ff - now_ff) > {32'd0, window_ff};

   assign busy = (state_ff != FSM_IDLE);
   assign csr_ready = (state_ff == FSM_IDLE) && !start;

   // new deadline for an add or a reset
   always_comb begin
      if (kind_ff == KIND_ADD || fnow_ff) new_dl = now_ff + ival_ff;
      else new_dl = deadline_ff[sidx] - period_ff[sidx] + ival_ff;
   end

   // single-result answer and front check against the scan minimum
   always_comb begin
      add_ok = (kind_ff == KIND_ADD) && free_found_ff;
      reset_ok = (kind_ff == KIND_RESET) && !noop_reset && sel_ok && active_ff[sidx];
      front_hit = !found || new_dl_ff < best_key ||
                  (new_dl_ff == best_key && tgt < best_idx);
      ap_notify = (add_ok || reset_ok) && front_hit && !notice_ff;
      expire_go = (kind_ff == KIND_EXPIRE) && found && (roll_ff || best_key <= now_ff);
      ap_wait = '0;
      if (kind_ff == KIND_WAIT) begin
         if (!found) ap_wait = ALL_ONES;
         else if (now_ff < best_key) ap_wait = best_key - now_ff;
      end
      priority if (kind_ff == KIND_ADD && !free_found_ff) begin
         ap_status = ST_FULL;
      end else if ((kind_ff == KIND_CANCEL || kind_ff == KIND_REFRESH) &&
                   !(sel_ok && active_ff[sidx])) begin
         ap_status = ST_INACTIVE;
      end else if (kind_ff == KIND_RESET && !noop_reset &&
                   !(sel_ok && active_ff[sidx])) begin
         ap_status = ST_INACTIVE;
      end else if (kind_ff == KIND_EXPIRE && !expire_go) begin
         ap_status = ST_NONE;
      end else begin
         ap_status = ST_OK;
      end
   end

   // final expiry result of the item
   assign xlast = !found || nres_ff == CNT_W'(TIMER_SLOTS - 1) || $countones(due_ff) == 1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE:  if (start) state_in = FSM_SCAN;
         FSM_SCAN:  if (scan_end) state_in = FSM_APPLY;
         FSM_APPLY: state_in = expire_go ? FSM_XSCAN : FSM_DONE;
         FSM_XSCAN: if (scan_end) state_in = FSM_XEMIT;
         FSM_XEMIT: state_in = xlast ? FSM_IDLE : FSM_XSCAN;
         FSM_DONE:  state_in = FSM_IDLE;
         default:   state_in = FSM_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         repeats_ff <= '0;
         due_ff <= '0;
         notice_ff <= 1'b0;
         prev_ff <= '0;
         window_ff <= DEFAULT_WINDOW;
         rsp_valid <= 1'b0;
         cnt_ff <= '0;
         nres_ff <= '0;
         free_found_ff <= 1'b0;
         for (int i = 0; i < TIMER_SLOTS; i++) begin
            deadline_ff[i] <= '0;
            period_ff[i] <= '0;
         end
      end else begin
         rsp_valid <= (state_ff == FSM_DONE) || (state_ff == FSM_XEMIT && found);
         if (csr_valid && csr_ready) window_ff <= csr_data;
         unique case (state_ff)
            FSM_IDLE: begin
               cnt_ff <= '0;
               free_found_ff <= 1'b0;
               nres_ff <= '0;
               if (start) begin
                  kind_ff <= kind_type'(req_kind);
                  slot_ff <= req_slot;
                  ival_ff <= req_interval_ms;
                  rec_ff <= req_recurring;
                  fnow_ff <= req_from_now;
                  now_ff <= req_now_ms;
               end
            end
            FSM_SCAN: begin
               // lowest free slot, found alongside the minimum
               if (!active_ff[cnt_ff] && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_ff <= cnt_ff;
               end
               new_dl_ff <= new_dl;
               roll_ff <= roll;
               cnt_ff <= cnt_ff + 1'b1;
            end
            FSM_APPLY: begin
               rsp_status <= ap_status;
               rsp_result_slot <= add_ok ? 4'(free_ff) : 4'd0;
               rsp_wait_ms <= ap_wait;
               rsp_front_notify <= ap_notify;
               rsp_last <= 1'b1;
               unique case (kind_ff)
                  KIND_ADD: begin
                     if (add_ok) begin
                        deadline_ff[free_ff] <= new_dl_ff;
                        period_ff[free_ff] <= ival_ff;
                        repeats_ff[free_ff] <= rec_ff;
                        active_ff[free_ff] <= 1'b1;
                     end
                     if (ap_notify) notice_ff <= 1'b1;
                  end
                  KIND_CANCEL: begin
                     if (sel_ok && active_ff[sidx]) active_ff[sidx] <= 1'b0;
                  end
                  KIND_REFRESH: begin
                     if (sel_ok && active_ff[sidx])
                        deadline_ff[sidx] <= now_ff + period_ff[sidx];
                  end
                  KIND_RESET: begin
                     if (reset_ok) begin
                        period_ff[sidx] <= ival_ff;
                        deadline_ff[sidx] <= new_dl_ff;
                     end
                     if (ap_notify) notice_ff <= 1'b1;
                  end
                  KIND_WAIT: begin
                     notice_ff <= 1'b0;
                  end
                  KIND_EXPIRE: begin
                     if (found) begin
                        prev_ff <= now_ff;
                        if (expire_go) begin
                           for (int i = 0; i < TIMER_SLOTS; i++) begin
                              snap_ff[i] <= deadline_ff[i];
                              due_ff[i] <= active_ff[i] &&
                                           (roll_ff || deadline_ff[i] <= now_ff);
                           end
                           cnt_ff <= '0;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            FSM_XSCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            FSM_XEMIT: begin
               // one due timer per walk, in deadline then slot order
               if (found) begin
                  due_ff[best_idx] <= 1'b0;
                  if (repeats_ff[best_idx])
                     deadline_ff[best_idx] <= now_ff + period_ff[best_idx];
                  else active_ff[best_idx] <= 1'b0;
                  nres_ff <= nres_ff + 1'b1;
                  rsp_status <= ST_OK;
                  rsp_result_slot <= 4'(best_idx);
                  rsp_wait_ms <= '0;
                  rsp_front_notify <= 1'b0;
                  // occupancy once every due one-shot timer has been freed
                  rsp_any_active <= |(active_ff & ~(due_ff & ~repeats_ff));
                  rsp_last <= xlast;
               end
               cnt_ff <= '0;
            end
            FSM_DONE: begin
               // single result goes out with the occupancy after the change
               rsp_any_active <= |active_ff;
            end
            default: ;
         endcase
      end
   end

   // sequencer and result checks
`ifndef SYNTHESIS
   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("result after last");
   a_nres: assert property (@(posedge clock) disable iff (reset)
      {1'b0, nres_ff} <= (CNT_W + 1)'(TIMER_SLOTS))
      else $error("too many expiry results");
   a_notify: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_front_notify |-> notice_ff)
      else $error("notice not recorded");
`endif
endmodule
